// File: design/aabb_pkg.sv
// Shared types and constants for the pairwise box overlap block.
// Holds the request/response transaction structs and the sequencer state encoding.
// No dependencies.
package aabb_pkg;

   localparam int MAX_BOXES_DEF  = 64;
   localparam int COORD_BITS_DEF = 16;
   localparam int FIELD_BITS     = 16;
   localparam int OUT_IDX_BITS   = 6;
   localparam int MAX_RESULTS    = 63;
   localparam int RES_CNT_BITS   = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic                          new_frame;
      logic signed [FIELD_BITS-1:0]  min_x;
      logic signed [FIELD_BITS-1:0]  min_y;
      logic signed [FIELD_BITS-1:0]  max_x;
      logic signed [FIELD_BITS-1:0]  max_y;
   } req_type;

   typedef struct packed {
      logic [OUT_IDX_BITS-1:0] earlier_index;
      logic [OUT_IDX_BITS-1:0] new_index;
      logic                    dropped;
      logic                    last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_FLUSH = 4'b0100,
      ST_DROP  = 4'b1000
   } state_type;

endpackage

// File: design/aabb_pairwise_overlap.sv
// Incremental all-pairs overlap test on 2D axis-aligned boxes.
// Depends on aabb_pkg (transaction structs, state encoding, defaults).
//
// Usage:
//  - req_valid/req_stall/req_data carry one box per transaction. new_frame
//    empties the box store before the box is tested.
//  - The box is compared with every stored box, lowest index first, one stored
//    box read from the box memory per cycle while the scan is not paused.
//    Each overlap yields one rsp transaction (earlier_index, new_index); the
//    final one has last set. A box overlapping nothing is stored with no response.
//  - If the store already holds MAX_BOXES boxes, the box is discarded and one
//    response with dropped and last set is returned.
//  - One box at a time: a box occupies the block until the scan, walked by the
//    scan counter through the single memory read port, and its write-back are
//    done; req_stall is high meanwhile.
//  - A stall on rsp holds the finished response in the output register; the
//    scan pauses once a second hit is waiting behind it.
//  - Reset (synchronous) empties the store and drops any transaction in
//    flight. Memory contents are not cleared; only entries below the count
//    are ever read.
module aabb_pairwise_overlap #(
   parameter int MAX_BOXES  = aabb_pkg::MAX_BOXES_DEF,
   parameter int COORD_BITS = aabb_pkg::COORD_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  aabb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output aabb_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(MAX_BOXES);
   localparam int CNT_W = $clog2(MAX_BOXES + 1);
   localparam int BOX_W = 4 * COORD_BITS;
   localparam int OIW   = aabb_pkg::OUT_IDX_BITS;
   localparam int RCW   = aabb_pkg::RES_CNT_BITS;
   localparam int FW    = aabb_pkg::FIELD_BITS;

   aabb_pkg::state_type state_ff, state_in;

   logic [BOX_W-1:0] box_mem_ff [MAX_BOXES];
   logic [BOX_W-1:0] mem_q_ff;
   logic [BOX_W-1:0] cur_box_ff, cur_box_in;
   logic [CNT_W-1:0] box_count_ff, box_count_in;
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic             rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic             pend_vld_ff, pend_vld_in;
   logic [IDX_W-1:0] pend_idx_ff, pend_idx_in;
   logic [RCW-1:0]   nres_ff, nres_in;
   logic             rsp_valid_ff, rsp_valid_in;
   aabb_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic             rd_en, wr_en, out_free, hit, advance, issue;
   logic [CNT_W-1:0] eff_count;
   logic [BOX_W-1:0] new_box;

   // Raw 16-bit fields taken as COORD_BITS-bit two's complement values
   logic [FW+COORD_BITS-1:0] ext_lx, ext_ly, ext_hx, ext_hy;
   assign ext_lx  = {{COORD_BITS{1'b0}}, req_data.min_x};
   assign ext_ly  = {{COORD_BITS{1'b0}}, req_data.min_y};
   assign ext_hx  = {{COORD_BITS{1'b0}}, req_data.max_x};
   assign ext_hy  = {{COORD_BITS{1'b0}}, req_data.max_y};
   assign new_box = {ext_hy[COORD_BITS-1:0], ext_hx[COORD_BITS-1:0],
                     ext_ly[COORD_BITS-1:0], ext_lx[COORD_BITS-1:0]};

   logic signed [COORD_BITS-1:0] a_lx, a_ly, a_hx, a_hy;
   logic signed [COORD_BITS-1:0] b_lx, b_ly, b_hx, b_hy;
   assign a_lx = $signed(mem_q_ff[0*COORD_BITS +: COORD_BITS]);
   assign a_ly = $signed(mem_q_ff[1*COORD_BITS +: COORD_BITS]);
   assign a_hx = $signed(mem_q_ff[2*COORD_BITS +: COORD_BITS]);
   assign a_hy = $signed(mem_q_ff[3*COORD_BITS +: COORD_BITS]);
   assign b_lx = $signed(cur_box_ff[0*COORD_BITS +: COORD_BITS]);
   assign b_ly = $signed(cur_box_ff[1*COORD_BITS +: COORD_BITS]);
   assign b_hx = $signed(cur_box_ff[2*COORD_BITS +: COORD_BITS]);
   assign b_hy = $signed(cur_box_ff[3*COORD_BITS +: COORD_BITS]);

   // Indices reported modulo 2**OIW
   logic [IDX_W+OIW-1:0] pend_idx_ext;
   logic [CNT_W+OIW-1:0] count_ext;
   assign pend_idx_ext = {{OIW{1'b0}}, pend_idx_ff};
   assign count_ext    = {{OIW{1'b0}}, box_count_ff};

   assign hit = rd_vld_ff && (nres_ff < RCW'(aabb_pkg::MAX_RESULTS)) &&
                (a_lx <= b_hx) && (a_hx >= b_lx) &&
                (a_ly <= b_hy) && (a_hy >= b_ly);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign eff_count = req_data.new_frame ? '0 : box_count_ff;
   assign issue     = rd_ptr_ff < box_count_ff;

   always_comb begin
      state_in     = state_ff;
      cur_box_in   = cur_box_ff;
      box_count_in = box_count_ff;
      rd_ptr_in    = rd_ptr_ff;
      rd_vld_in    = rd_vld_ff;
      cmp_idx_in   = cmp_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_idx_in  = pend_idx_ff;
      nres_in      = nres_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      advance      = 1'b0;

      unique case (state_ff)
         aabb_pkg::ST_IDLE: begin
            if (req_valid) begin
               cur_box_in   = new_box;
               box_count_in = eff_count;
               rd_ptr_in    = '0;
               rd_vld_in    = 1'b0;
               pend_vld_in  = 1'b0;
               nres_in      = '0;
               if (eff_count >= CNT_W'(MAX_BOXES)) begin
                  state_in = aabb_pkg::ST_DROP;
               end else begin
                  state_in = aabb_pkg::ST_SCAN;
               end
            end
         end
         aabb_pkg::ST_SCAN: begin
            // a second hit waits until the held one can move to the output
            advance = !(hit && pend_vld_ff && !out_free);
            if (advance) begin
               if (hit) begin
                  if (pend_vld_ff) begin
                     rsp_valid_in              = 1'b1;
                     rsp_data_in.earlier_index = pend_idx_ext[OIW-1:0];
                     rsp_data_in.new_index     = count_ext[OIW-1:0];
                     rsp_data_in.dropped       = 1'b0;
                     rsp_data_in.last          = 1'b0;
                  end
                  pend_vld_in = 1'b1;
                  pend_idx_in = cmp_idx_ff;
                  nres_in     = nres_ff + RCW'(1);
               end
               rd_vld_in = issue;
               if (issue) begin
                  rd_en      = 1'b1;
                  cmp_idx_in = rd_ptr_ff[IDX_W-1:0];
                  rd_ptr_in  = rd_ptr_ff + CNT_W'(1);
               end else begin
                  state_in = aabb_pkg::ST_FLUSH;
               end
            end
         end
         aabb_pkg::ST_FLUSH: begin
            if (!pend_vld_ff || out_free) begin
               if (pend_vld_ff) begin
                  rsp_valid_in              = 1'b1;
                  rsp_data_in.earlier_index = pend_idx_ext[OIW-1:0];
                  rsp_data_in.new_index     = count_ext[OIW-1:0];
                  rsp_data_in.dropped       = 1'b0;
                  rsp_data_in.last          = 1'b1;
               end
               pend_vld_in  = 1'b0;
               wr_en        = 1'b1;
               box_count_in = box_count_ff + CNT_W'(1);
               state_in     = aabb_pkg::ST_IDLE;
            end
         end
         aabb_pkg::ST_DROP: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.earlier_index = '0;
               rsp_data_in.new_index     = '0;
               rsp_data_in.dropped       = 1'b1;
               rsp_data_in.last          = 1'b1;
               state_in                  = aabb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = aabb_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aabb_pkg::ST_IDLE;
         box_count_ff <= '0;
         rd_ptr_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         pend_vld_ff  <= 1'b0;
         nres_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         box_count_ff <= box_count_in;
         rd_ptr_ff    <= rd_ptr_in;
         rd_vld_ff    <= rd_vld_in;
         pend_vld_ff  <= pend_vld_in;
         nres_ff      <= nres_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_box_ff  <= cur_box_in;
      cmp_idx_ff  <= cmp_idx_in;
      pend_idx_ff <= pend_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Box store: one read port, one write port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         mem_q_ff <= box_mem_ff[rd_ptr_ff[IDX_W-1:0]];
      end
      if (wr_en) begin
         box_mem_ff[box_count_ff[IDX_W-1:0]] <= cur_box_ff;
      end
   end

   assign req_stall = (state_ff != aabb_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      box_count_ff <= CNT_W'(MAX_BOXES))
      else $error("box count above store depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request channel open right after accepting a box");

   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == aabb_pkg::ST_IDLE) |-> (!pend_vld_ff && !rd_vld_ff))
      else $error("leftover hit or read in idle");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> ({{(CNT_W-IDX_W){1'b0}}, cmp_idx_ff} < box_count_ff))
      else $error("compare on an entry beyond the box count");
`endif

endmodule

// File: sim/tb_aabb_pairwise_overlap.sv
// Self-checking testbench for aabb_pairwise_overlap: directed and random boxes
// are checked against an in-bench predictor of the overlap pairs.
// Depends on aabb_pkg and the aabb_pairwise_overlap RTL.
module tb_aabb_pairwise_overlap;

   localparam int STORE_DEPTH   = aabb_pkg::MAX_BOXES_DEF;
   localparam int TARGET_ITEMS  = 260;
   localparam int SETTLE_CYCLES = 100;
   localparam int DRAIN_LIMIT   = 200000;

   typedef struct {
      aabb_pkg::req_type box;
      bit                drain_first;
   } pending_box_type;

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   aabb_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   aabb_pkg::rsp_type rsp_data;

   pending_box_type   pending_boxes[$];
   aabb_pkg::rsp_type expected_pairs[$];
   aabb_pkg::req_type frame_boxes[STORE_DEPTH];
   int unsigned       frame_box_count = 0;

   int unsigned       mismatches = 0;
   int unsigned       gap_left   = 0;
   int unsigned       quiet_left = 0;
   int unsigned       stall_left = 0;
   int unsigned       free_left  = 0;
   int                frame_cx   = 0;
   int                frame_cy   = 0;
   aabb_pkg::rsp_type want;
   logic              drive_valid;

   aabb_pairwise_overlap i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Predictor: tests the box against the frame so far, queues the pairs it
   // yields, then stores it (or queues a drop when the frame is full).
   function automatic void add_box_expect_pairs(aabb_pkg::req_type b);
      aabb_pkg::rsp_type pair;
      aabb_pkg::req_type s;
      int unsigned       hits;
      hits = 0;
      if (b.new_frame)
         frame_box_count = 0;
      if (frame_box_count >= STORE_DEPTH) begin
         pair = '{earlier_index: '0, new_index: '0, dropped: 1'b1, last: 1'b1};
         expected_pairs = {expected_pairs, pair};
         return;
      end
      for (int i = 0; i < frame_box_count; i++) begin
         s = frame_boxes[i];
         if (hits < aabb_pkg::MAX_RESULTS &&
             $signed(s.min_x) <= $signed(b.max_x) && $signed(s.max_x) >= $signed(b.min_x) &&
             $signed(s.min_y) <= $signed(b.max_y) && $signed(s.max_y) >= $signed(b.min_y)) begin
            pair.earlier_index = aabb_pkg::OUT_IDX_BITS'(i);
            pair.new_index     = aabb_pkg::OUT_IDX_BITS'(frame_box_count);
            pair.dropped       = 1'b0;
            pair.last          = 1'b0;
            expected_pairs = {expected_pairs, pair};
            hits++;
         end
      end
      if (hits > 0) begin
         pair = expected_pairs[expected_pairs.size() - 1];
         pair.last = 1'b1;
         expected_pairs[expected_pairs.size() - 1] = pair;
      end
      frame_boxes[frame_box_count] = b;
      frame_box_count++;
   endfunction

   function automatic void queue_box(bit nf, int lx, int ly, int hx, int hy, bit drain = 1'b0);
      pending_box_type p;
      p.box.new_frame = nf;
      p.box.min_x     = 16'(lx);
      p.box.min_y     = 16'(ly);
      p.box.max_x     = 16'(hx);
      p.box.max_y     = 16'(hy);
      p.drain_first   = drain;
      pending_boxes = {pending_boxes, p};
   endfunction

   // Mostly boxes clustered around the frame center so pairs are common;
   // the rest are raw random corners, often inverted.
   function automatic void queue_random_box(bit nf, bit drain);
      int cx, cy, hw, hh;
      if ($urandom_range(0, 99) < 20) begin
         queue_box(nf, int'($urandom), int'($urandom), int'($urandom), int'($urandom), drain);
         return;
      end
      cx = frame_cx + int'($urandom_range(0, 4000)) - 2000;
      cy = frame_cy + int'($urandom_range(0, 4000)) - 2000;
      hw = int'($urandom_range(0, 1200));
      hh = int'($urandom_range(0, 1200));
      queue_box(nf, cx - hw, cy - hh, cx + hw, cy + hh, drain);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if (roll < 55)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(8, 30);
      quiet_left = $urandom_range(10, 40);
      return 0;
   endfunction

   function automatic logic next_rsp_stall();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (stall_left > 0) begin
         stall_left--;
         return 1'b1;
      end
      if (free_left > 0) begin
         free_left--;
         return 1'b0;
      end
      if (roll < 50)
         free_left = $urandom_range(1, 6);
      else if (roll < 60)
         free_left = $urandom_range(20, 80);
      else if (roll < 92)
         stall_left = $urandom_range(0, 2);
      else
         stall_left = $urandom_range(8, 40);
      return 1'b1;
   endfunction

   function automatic void compare_field(string name, int unsigned exp_val, int unsigned got_val);
      if (exp_val != got_val) begin
         $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
         mismatches++;
      end
   endfunction

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         drive_valid = req_valid;
         if (req_valid && !req_stall) begin
            add_box_expect_pairs(req_data);
            gap_left    = pick_gap();
            drive_valid = 1'b0;
         end
         if (!drive_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_boxes.size() > 0 &&
                         !(pending_boxes[0].drain_first && expected_pairs.size() != 0)) begin
               req_data    <= pending_boxes[0].box;
               drive_valid = 1'b1;
               void'(pending_boxes.pop_front());
            end
         end
         req_valid <= drive_valid;
      end
   end

   // Response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pairs.size() == 0) begin
               $error("unexpected result transaction: earlier_index=%0d new_index=%0d dropped=%0b",
                      rsp_data.earlier_index, rsp_data.new_index, rsp_data.dropped);
               mismatches++;
            end else begin
               want = expected_pairs.pop_front();
               compare_field("earlier_index", want.earlier_index, rsp_data.earlier_index);
               compare_field("new_index", want.new_index, rsp_data.new_index);
               compare_field("dropped", want.dropped, rsp_data.dropped);
               compare_field("last", want.last, rsp_data.last);
            end
         end
         rsp_stall <= next_rsp_stall();
      end
   end

   initial begin
      int unsigned frame_len;
      int unsigned waited;
      // directed: edges, touching boxes, extremes, inverted box
      queue_box(1'b1, 0, 0, 256, 256);
      queue_box(1'b0, 256, 0, 512, 256);          // shares an edge with box 0
      queue_box(1'b0, 512, 256, 768, 512);        // touches box 1 at a corner
      queue_box(1'b0, -256, -256, -1, -1);        // misses box 0 by one, the others by more
      queue_box(1'b0, -32768, -32768, 32767, 32767);
      queue_box(1'b0, 100, 100, 50, 50);          // inverted
      queue_box(1'b0, -32768, -32768, -32768, -32768);
      queue_box(1'b0, 32767, 32767, 32767, 32767);
      queue_box(1'b0, 21845, -21846, 21845, -21846);
      queue_box(1'b1, 1000, 1000, 2000, 2000, 1'b1);
      queue_box(1'b0, 1000, 1000, 2000, 2000);
      queue_box(1'b0, 2001, 2001, 3000, 3000);
      // full frame: every box meets every other, then two drops
      for (int i = 0; i < STORE_DEPTH + 2; i++)
         queue_box(i == 0, -32768, -32768, 32767, 32767, i == 0);
      queue_box(1'b1, 0, 0, 0, 0);

      while (pending_boxes.size() < TARGET_ITEMS) begin
         if ($urandom_range(0, 99) < 4)
            frame_len = $urandom_range(60, 68);
         else if ($urandom_range(0, 99) < 15)
            frame_len = $urandom_range(20, 40);
         else
            frame_len = $urandom_range(1, 12);
         frame_cx = int'($urandom_range(0, 56000)) - 28000;
         frame_cy = int'($urandom_range(0, 56000)) - 28000;
         for (int i = 0; i < frame_len && pending_boxes.size() < TARGET_ITEMS; i++)
            queue_random_box(i == 0, i == 0 && $urandom_range(0, 99) < 10);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_boxes.size() != 0 || req_valid)
         @(posedge clock);
      waited = 0;
      while (expected_pairs.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_pairs.size() != 0) begin
         $error("%0d expected result transactions never arrived", expected_pairs.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #50000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

// File: aabb_pairwise_overlap.f
design/aabb_pkg.sv
design/aabb_pairwise_overlap.sv
sim/tb_aabb_pairwise_overlap.sv
